// File: rtl/mp2_pkg.sv
// mp2_pkg: shared types and constants for the 2x2 stride-2 max pool unit
// no dependencies

package mp2_pkg;

  localparam int unsigned CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IN_WIDTH    = 3'd0,
    REG_IN_HEIGHT   = 3'd1,
    REG_OUT_WIDTH   = 3'd2,
    REG_OUT_HEIGHT  = 3'd3,
    REG_PLANE_COUNT = 3'd4
  } cfg_reg_t;

  // one classified sample, front to back
  typedef struct packed {
    logic [31:0] sample;
    logic        odd_col;
    logic        odd_row;
    logic        emit;
    logic        plane_end;
    logic        job_end;
  } mp2_op_t;

  // ieee ordered a < b on bit patterns, false when either is nan
  function automatic logic f_less(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] ka;
    logic [31:0] kb;
    ka = a[31] ? ~a : (a | 32'h8000_0000);
    kb = b[31] ? ~b : (b | 32'h8000_0000);
    if ((a[30:0] > 31'h7F80_0000) || (b[30:0] > 31'h7F80_0000)) begin
      return 1'b0;
    end
    if ((a[30:0] == 31'd0) && (b[30:0] == 31'd0)) begin
      return 1'b0;
    end
    return ka < kb;
  endfunction

endpackage

// File: rtl/mp2_ram.sv
// mp2_ram: generic single-port-write, single-read ram with registered read
// no dependencies

module mp2_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: rtl/mp2_front.sv
// mp2_front: counts columns, rows and planes and classifies each sample
// depends on mp2_pkg

module mp2_front #(
  parameter int unsigned MAX_WIDTH  = 256,
  parameter int unsigned MAX_HEIGHT = 1024
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [8:0]            in_width,
  input  logic [10:0]           in_height,
  input  logic [7:0]            out_width,
  input  logic [9:0]            out_height,
  input  logic [15:0]           plane_count,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [31:0]           in_sample,
  output logic                  op_valid,
  input  logic                  op_ready,
  output mp2_pkg::mp2_op_t      op,
  output logic [$clog2(MAX_WIDTH/2)-1:0] op_wx
);

  localparam int unsigned CW = $clog2(MAX_WIDTH);
  localparam int unsigned RW = $clog2(MAX_HEIGHT);
  localparam int unsigned XW = $clog2(MAX_WIDTH/2);

  logic [CW-1:0] col_r;
  logic [RW-1:0] row_r;
  logic [15:0]   plane_r;
  logic [12:0]   w, h;
  logic [12:0]   eow, eoh;
  logic [15:0]   last_plane;
  logic          last_col, last_row, in_win, pend, acc;
  logic [12:0]   wx, wy;

  always_comb begin
    w = (in_width < 9'd2) ? 13'd2 : 13'(in_width);
    if (w > 13'(MAX_WIDTH)) w = 13'(MAX_WIDTH);
    h = (in_height < 11'd2) ? 13'd2 : 13'(in_height);
    if (h > 13'(MAX_HEIGHT)) h = 13'(MAX_HEIGHT);
    eow = (13'(out_width) < (w >> 1)) ? 13'(out_width) : (w >> 1);
    eoh = (13'(out_height) < (h >> 1)) ? 13'(out_height) : (h >> 1);
    last_plane = plane_count - 16'd1;
    wx = 13'(col_r >> 1);
    wy = 13'(row_r >> 1);
    last_col = 13'(col_r) >= w - 13'd1;
    last_row = 13'(row_r) >= h - 13'd1;
    in_win = (wx < eow) && (wy < eoh);
    pend = (wx == eow - 13'd1) && (wy == eoh - 13'd1);
  end

  assign in_ready = op_ready;
  assign acc      = in_valid && op_ready;
  assign op_valid = in_valid;
  assign op_wx    = XW'(col_r >> 1);

  always_comb begin
    op.sample    = in_sample;
    op.odd_col   = col_r[0];
    op.odd_row   = row_r[0];
    op.emit      = col_r[0] && row_r[0] && in_win;
    op.plane_end = pend;
    op.job_end   = pend && (plane_r == last_plane);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r   <= '0;
      row_r   <= '0;
      plane_r <= '0;
    end else if (acc) begin
      if (last_col) begin
        col_r <= '0;
        if (last_row) begin
          row_r   <= '0;
          plane_r <= (plane_r == last_plane) ? 16'd0 : plane_r + 16'd1;
        end else begin
          row_r <= row_r + RW'(1);
        end
      end else begin
        col_r <= col_r + CW'(1);
      end
    end
  end

endmodule

// File: rtl/mp2_back.sv
// mp2_back: line store, pair and window compares, output register
// depends on mp2_pkg, mp2_ram

module mp2_back #(
  parameter int unsigned MAX_WIDTH = 256
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  op_valid,
  output logic                  op_ready,
  input  mp2_pkg::mp2_op_t      op,
  input  logic [$clog2(MAX_WIDTH/2)-1:0] op_wx,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [31:0]           out_pooled,
  output logic                  out_plane_end,
  output logic                  out_job_end
);

  localparam int unsigned XW = $clog2(MAX_WIDTH/2);

  // stage 1: hold + line read; stage 2: compares + output
  logic        s1_v_r;
  mp2_pkg::mp2_op_t s1_r;
  logic [31:0] s1_left_r;
  logic [31:0] left_r;
  logic [31:0] line_q, m1, m2, pair;
  logic        s1_go, acc, ov_r, wr;
  logic [31:0] opool_r;
  logic        ope_r, oje_r;
  logic [XW-1:0] s1_wx_r;

  assign s1_go    = s1_v_r && (!ov_r || out_tready || !s1_r.emit);
  assign op_ready = !s1_v_r || s1_go;
  assign acc      = op_valid && op_ready;
  assign pair     = mp2_pkg::f_less(s1_left_r, s1_r.sample) ? s1_r.sample : s1_left_r;
  assign wr       = s1_go && s1_r.odd_col && !s1_r.odd_row;
  assign m1       = mp2_pkg::f_less(line_q, s1_left_r) ? s1_left_r : line_q;
  assign m2       = mp2_pkg::f_less(m1, s1_r.sample) ? s1_r.sample : m1;

  mp2_ram #(.WIDTH(32), .DEPTH(MAX_WIDTH/2)) u_line (
    .clk     (clk),
    .wr_en   (wr),
    .wr_addr (s1_wx_r),
    .wr_data (pair),
    .rd_en   (acc),
    .rd_addr (op_wx),
    .rd_data (line_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      ov_r   <= 1'b0;
      left_r <= '0;
    end else begin
      if (acc) begin
        s1_v_r    <= 1'b1;
        s1_r      <= op;
        s1_wx_r   <= op_wx;
        s1_left_r <= left_r;
        if (!op.odd_col) left_r <= op.sample;
      end else if (s1_go) begin
        s1_v_r <= 1'b0;
      end
      if (s1_go && s1_r.emit) begin
        ov_r    <= 1'b1;
        opool_r <= m2;
        ope_r   <= s1_r.plane_end;
        oje_r   <= s1_r.job_end;
      end else if (out_tready) begin
        ov_r <= 1'b0;
      end
    end
  end

  assign out_tvalid    = ov_r;
  assign out_pooled    = opool_r;
  assign out_plane_end = ope_r;
  assign out_job_end   = oje_r;

endmodule

// File: rtl/max_pool_2x2_stride2_unit.sv
// max_pool_2x2_stride2_unit: top level of the 2x2 stride-2 float max pool
// depends on mp2_pkg, mp2_front, mp2_back, mp2_ram
//
// Takes one float32 sample a beat in raster order, one beat per cycle
// sustained unless the output stalls; out_tvalid rises once the window's
// bottom-right sample has passed the stage-1 register into the output
// register. The line store of top-pair maxima is a single ram with one
// write and one registered read per cycle, which sets the two-stage path.
// Trailing odd columns/rows, and windows beyond output size, give no beat.

module max_pool_2x2_stride2_unit #(
  parameter int unsigned MAX_WIDTH  = 256,
  parameter int unsigned MAX_HEIGHT = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // sample
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // pooled
  output logic [1:0]  out_tuser   // plane_end, job_end
);

  logic [8:0]  in_width_r;
  logic [10:0] in_height_r;
  logic [7:0]  out_width_r;
  logic [9:0]  out_height_r;
  logic [15:0] plane_count_r;
  logic        op_valid, op_ready;
  mp2_pkg::mp2_op_t op;
  logic [$clog2(MAX_WIDTH/2)-1:0] op_wx;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_width_r    <= 9'd2;
      in_height_r   <= 11'd2;
      out_width_r   <= 8'd1;
      out_height_r  <= 10'd1;
      plane_count_r <= 16'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        mp2_pkg::REG_IN_WIDTH:    in_width_r    <= cfg_data[8:0];
        mp2_pkg::REG_IN_HEIGHT:   in_height_r   <= cfg_data[10:0];
        mp2_pkg::REG_OUT_WIDTH:   out_width_r   <= cfg_data[7:0];
        mp2_pkg::REG_OUT_HEIGHT:  out_height_r  <= cfg_data[9:0];
        mp2_pkg::REG_PLANE_COUNT: plane_count_r <= cfg_data;
        default: ;
      endcase
    end
  end

  mp2_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_width    (in_width_r),
    .in_height   (in_height_r),
    .out_width   (out_width_r),
    .out_height  (out_height_r),
    .plane_count (plane_count_r),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .in_sample   (in_tdata),
    .op_valid    (op_valid),
    .op_ready    (op_ready),
    .op          (op),
    .op_wx       (op_wx)
  );

  mp2_back #(.MAX_WIDTH(MAX_WIDTH)) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .op_valid      (op_valid),
    .op_ready      (op_ready),
    .op            (op),
    .op_wx         (op_wx),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_pooled    (out_tdata),
    .out_plane_end (out_tuser[0]),
    .out_job_end   (out_tuser[1])
  );

endmodule

// File: rtl/mp2_checker.sv
// mp2_checker: port-level assertions for max_pool_2x2_stride2_unit
// depends on max_pool_2x2_stride2_unit ports; bound below

module mp2_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic [1:0]  out_tuser
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output beat dropped or changed");

  a_job: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] |-> out_tuser[0])
    else $error("job end without plane end");

  a_rst: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("valid after reset");

endmodule

bind max_pool_2x2_stride2_unit mp2_checker u_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

// File: tb/sv/tb_max_pool_2x2_stride2_unit.sv
// tb_max_pool_2x2_stride2_unit: self-checking testbench for the 2x2 stride-2 float max pool
// depends on mp2_pkg and max_pool_2x2_stride2_unit; predicts each pooled beat and compares
`timescale 1ns / 1ps

module tb_max_pool_2x2_stride2_unit;

  localparam int unsigned MAX_W = 256;
  localparam int unsigned MAX_H = 1024;
  localparam int unsigned LINE_D = MAX_W / 2;
  localparam longint CYCLE_LIMIT = 2000000;

  typedef struct packed {
    logic [31:0] pooled;
    logic        plane_end;
    logic        job_end;
  } pool_res_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_data;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;   // sample
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;  // pooled
  logic [1:0]  out_tuser;  // plane_end, job_end

  max_pool_2x2_stride2_unit i_dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser)
  );

  // predictor state
  int unsigned cfg_w, cfg_h, cfg_ow, cfg_oh, cfg_planes;
  logic [31:0] top_pair_max [LINE_D];
  logic [31:0] left_sample;
  int unsigned col_pos, row_pos, plane_pos;

  pool_res_t   pooled_q[$];
  int          err_count;
  longint      cycle_count = 0;
  int          send_idle_pct;
  int          recv_stall_pct;
  int          hold_recv = 0;
  int          stall_req;
  int          stall_seen = 0;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic logic pool_less(logic [31:0] a, logic [31:0] b);
    logic [31:0] ka;
    logic [31:0] kb;
    if ((a[30:0] > 31'h7F80_0000) || (b[30:0] > 31'h7F80_0000)) return 1'b0;
    if ((a[30:0] == 31'd0) && (b[30:0] == 31'd0)) return 1'b0;
    ka = a[31] ? ~a : {1'b1, a[30:0]};
    kb = b[31] ? ~b : {1'b1, b[30:0]};
    return ka < kb;
  endfunction

  function automatic int unsigned clamp_dim(int unsigned v, int unsigned hi);
    if (v < 2) return 2;
    return (v > hi) ? hi : v;
  endfunction

  // advance the window predictor by one accepted sample
  task automatic predict_sample(input logic [31:0] s);
    int unsigned w, h, eow, eoh, last_pl, wx, wy;
    logic [31:0] m;
    logic pend;
    w = clamp_dim(cfg_w, MAX_W);
    h = clamp_dim(cfg_h, MAX_H);
    eow = (cfg_ow < w / 2) ? cfg_ow : w / 2;
    eoh = (cfg_oh < h / 2) ? cfg_oh : h / 2;
    last_pl = (cfg_planes + 16'hFFFF) & 16'hFFFF;
    wx = col_pos >> 1;
    wy = row_pos >> 1;
    if (!col_pos[0]) begin
      left_sample = s;
    end else if (!row_pos[0]) begin
      if (wx < LINE_D) begin
        m = left_sample;
        if (pool_less(m, s)) m = s;
        top_pair_max[wx] = m;
      end
    end else if (wx < eow && wy < eoh) begin
      m = top_pair_max[wx];
      if (pool_less(m, left_sample)) m = left_sample;
      if (pool_less(m, s)) m = s;
      pend = (wx == eow - 1) && (wy == eoh - 1);
      pooled_q.push_back('{m, pend, pend && (plane_pos == last_pl)});
    end
    if (col_pos >= w - 1) begin
      col_pos = 0;
      if (row_pos >= h - 1) begin
        row_pos = 0;
        plane_pos = (plane_pos == last_pl) ? 0 : ((plane_pos + 1) & 16'hFFFF);
      end else begin
        row_pos++;
      end
    end else begin
      col_pos++;
    end
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %h want %h at cycle %0d", what, got, want, cycle_count);
    err_count++;
  endtask

  // result checker
  always @(posedge clk) begin
    pool_res_t exp_res;
    cycle_count <= cycle_count + 1;
    if (rst_n && out_tvalid && out_tready) begin
      if (pooled_q.size() == 0) begin
        report_mismatch("unexpected beat", out_tdata, 32'd0);
      end else begin
        exp_res = pooled_q.pop_front();
        if (out_tdata !== exp_res.pooled)
          report_mismatch("pooled", out_tdata, exp_res.pooled);
        if (out_tuser[0] !== exp_res.plane_end)
          report_mismatch("plane_end", 32'(out_tuser[0]), 32'(exp_res.plane_end));
        if (out_tuser[1] !== exp_res.job_end)
          report_mismatch("job_end", 32'(out_tuser[1]), 32'(exp_res.job_end));
      end
    end
  end

  // receiver stalls, with a long hold-off on request
  always @(posedge clk) begin
    if (hold_recv > 0) begin
      out_tready <= 1'b0;
      hold_recv <= hold_recv - 1;
    end else if (stall_seen != stall_req) begin
      out_tready <= 1'b0;
      hold_recv <= 199;
      stall_seen <= stall_req;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout at cycle %0d", cycle_count);
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic send_sample(input logic [31:0] s);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= s;
    do @(posedge clk); while (!in_tready);
    predict_sample(s);
  endtask

  task automatic drain_results;
    in_tvalid <= 1'b0;
    while (pooled_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input mp2_pkg::cfg_reg_t idx, input int unsigned val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[15:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      mp2_pkg::REG_IN_WIDTH:    cfg_w = val & 9'h1FF;
      mp2_pkg::REG_IN_HEIGHT:   cfg_h = val & 11'h7FF;
      mp2_pkg::REG_OUT_WIDTH:   cfg_ow = val & 8'hFF;
      mp2_pkg::REG_OUT_HEIGHT:  cfg_oh = val & 10'h3FF;
      mp2_pkg::REG_PLANE_COUNT: cfg_planes = val & 16'hFFFF;
      default: ;
    endcase
  endtask

  // job setup from a plane start; keeps sizes consistent
  task automatic set_job(input int unsigned w, input int unsigned h,
                         input int unsigned ow, input int unsigned oh,
                         input int unsigned np);
    drain_results();
    write_reg(mp2_pkg::REG_IN_WIDTH, w);
    write_reg(mp2_pkg::REG_IN_HEIGHT, h);
    write_reg(mp2_pkg::REG_OUT_WIDTH, ow);
    write_reg(mp2_pkg::REG_OUT_HEIGHT, oh);
    write_reg(mp2_pkg::REG_PLANE_COUNT, np);
  endtask

  function automatic logic [31:0] rand_float();
    logic [31:0] v;
    v = $urandom();
    case ($urandom_range(5))
      0: v = {v[31], 31'd0};
      1: v = {v[31], 8'hFF, 23'd0};
      2: v = {v[31], 8'd0, v[22:0]};
      3: v = {v[31], 8'h7F, v[3:0], 19'd0};
      default: if (v[30:23] == 8'hFF) v[30:23] = 8'hFE;
    endcase
    return v;
  endfunction

  task automatic send_planes(input int unsigned count, input int mode);
    int unsigned total;
    total = clamp_dim(cfg_w, MAX_W) * clamp_dim(cfg_h, MAX_H) * count;
    for (int unsigned i = 0; i < total; i++)
      send_sample(mode == 1 ? {1'b0, 8'h80, 23'(i)} : rand_float());
  endtask

  task automatic test_directed_extremes;
    // tie cases: +0 then -0, -0 then +0, inf and denormals
    set_job(2, 2, 1, 1, 1);
    send_sample(32'h0000_0000); send_sample(32'h8000_0000);
    send_sample(32'h8000_0000); send_sample(32'h0000_0000);
    send_sample(32'h8000_0000); send_sample(32'h0000_0000);
    send_sample(32'h0000_0000); send_sample(32'h8000_0000);
    send_sample(32'hFF80_0000); send_sample(32'h8000_0001);
    send_sample(32'h7F7F_FFFF); send_sample(32'h7F80_0000);
    send_sample(32'hFFFF_FFFF & 32'hFF7F_FFFF); send_sample(32'hFF80_0000);
    send_sample(32'h0000_0001); send_sample(32'hFFFF_FFFF & 32'h807F_FFFF);
    // odd width and height, window beyond output size
    set_job(5, 3, 1, 1, 2);
    send_planes(2, 0);
  endtask

  task automatic test_config_corners;
    // zero output size, clamped dims, plane count zero
    set_job(0, 1, 0, 1, 3);
    send_planes(3, 0);
    set_job(300, 2, 128, 1, 1);
    send_planes(1, 0);
    set_job(2, 2, 1, 1, 0);
    send_planes(3, 0);
    // bring the plane counter back to zero
    set_job(2, 2, 1, 1, 4);
    send_planes(1, 0);
    set_job(511, 2047, 255, 1023, 65535);
    drain_results();
    set_job(2, 2, 1, 1, 1);
  endtask

  task automatic test_random_jobs(input int unsigned n_items);
    int unsigned sent;
    int unsigned w, h, np;
    sent = 0;
    while (sent < n_items) begin
      w = $urandom_range(2, 9);
      h = $urandom_range(2, 7);
      np = $urandom_range(1, 3);
      set_job(w, h, $urandom_range(0, w / 2 + 1), $urandom_range(0, h / 2 + 1), np);
      send_planes(np, 0);
      sent += w * h * np;
    end
  endtask

  task automatic test_backpressure;
    set_job(16, 2, 8, 1, 2);
    stall_req++;
    send_planes(2, 1);
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    stall_req = 0;
    err_count = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    cfg_w = 2; cfg_h = 2; cfg_ow = 1; cfg_oh = 1; cfg_planes = 1;
    left_sample = '0; col_pos = 0; row_pos = 0; plane_pos = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    test_directed_extremes();
    test_config_corners();
    test_backpressure();
    test_random_jobs(40);
    send_idle_pct = 51;
    test_random_jobs(40);
    send_idle_pct = 0;
    recv_stall_pct = 51;
    test_random_jobs(40);
    send_idle_pct = 6;
    recv_stall_pct = 6;
    test_random_jobs(40);
    drain_results();
    if (err_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/mp2_pkg.sv
rtl/mp2_ram.sv
rtl/mp2_front.sv
rtl/mp2_back.sv
rtl/max_pool_2x2_stride2_unit.sv
rtl/mp2_checker.sv
tb/sv/tb_max_pool_2x2_stride2_unit.sv
